[hw/rtl/jst_pkg.sv]
// Shared types and constants of the JSON stream tokenizer.
package jst_pkg;

  localparam int MAX_RES = 5;
  localparam int Q_DEPTH = 4;

  localparam logic [3:0] EV_OPEN_OBJ  = 4'd0;
  localparam logic [3:0] EV_CLOSE_OBJ = 4'd1;
  localparam logic [3:0] EV_OPEN_ARR  = 4'd2;
  localparam logic [3:0] EV_CLOSE_ARR = 4'd3;
  localparam logic [3:0] EV_KEY       = 4'd4;
  localparam logic [3:0] EV_STR       = 4'd5;
  localparam logic [3:0] EV_STR_END   = 4'd6;
  localparam logic [3:0] EV_NUM       = 4'd7;
  localparam logic [3:0] EV_TRUE      = 4'd8;
  localparam logic [3:0] EV_DOC_OK    = 4'd11;
  localparam logic [3:0] EV_ERROR     = 4'd12;

  // All results caused by one input word.
  typedef struct packed {
    logic [2:0]                cnt;
    logic [MAX_RES-1:0][3:0]   ev;
    logic [MAX_RES-1:0][7:0]   data;
    logic [MAX_RES-1:0][5:0]   depth;
  } bundle_t;

endpackage

[hw/rtl/jst_ram.sv]
// Generic single-port-write RAM with registered read.
module jst_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/jst_front.sv]
// Front end: grammar state machine that turns one byte into a bundle of results.
module jst_front import jst_pkg::*; #(
  parameter int MAX_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] byte_value,
  input  logic       final_byte,
  output logic       push,
  output bundle_t    bundle
);

  localparam int SPW = $clog2(MAX_DEPTH + 1);
  localparam int AW  = MAX_DEPTH > 1 ? $clog2(MAX_DEPTH) : 1;
  localparam logic [SPW-1:0] SP_MAX = SPW'(MAX_DEPTH);

  localparam logic [4:0] M_BOM       = 5'd0;
  localparam logic [4:0] M_VALUE     = 5'd1;
  localparam logic [4:0] M_AFTER     = 5'd2;
  localparam logic [4:0] M_OBJ_FIRST = 5'd3;
  localparam logic [4:0] M_KEY       = 5'd4;
  localparam logic [4:0] M_COLON     = 5'd5;
  localparam logic [4:0] M_ARR_FIRST = 5'd6;
  localparam logic [4:0] M_NUMBER    = 5'd7;
  localparam logic [4:0] M_LIT_TRUE  = 5'd8;
  localparam logic [4:0] M_LIT_FALSE = 5'd9;
  localparam logic [4:0] M_LIT_NULL  = 5'd10;

  localparam logic [2:0] S_CHAR        = 3'd0;
  localparam logic [2:0] S_ESC         = 3'd1;
  localparam logic [2:0] S_HEX         = 3'd2;
  localparam logic [2:0] S_AFTER_HI    = 3'd3;
  localparam logic [2:0] S_AFTER_HI_BS = 3'd4;
  localparam logic [2:0] S_LOW_HEX     = 3'd5;

  typedef struct packed {
    logic [4:0]     mode;
    logic [2:0]     lp;
    logic [15:0]    ha;
    logic [2:0]     hc;
    logic [15:0]    hs;
    logic [1:0]     bp;
    logic           er;
    logic [SPW-1:0] sp;
  } st_t;

  typedef struct packed {
    st_t            st;
    logic           again;
    logic [2:0]     n;
    logic [3:0]     ev;
    logic [3:0][7:0] d;
    logic           push;
    logic           kind;
  } pass_t;

  localparam st_t RST_ST = '{mode: M_BOM, lp: 3'd0, ha: 16'd0, hc: 3'd0, hs: 16'd0,
                             bp: 2'd0, er: 1'b0, sp: '0};

  function automatic logic is_ws(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic logic is_num(logic [7:0] b);
    return (b >= "0" && b <= "9") || b == "." || b == "e" || b == "E" ||
           b == "-" || b == "+";
  endfunction

  // Bit 4 is the digit-valid flag.
  function automatic logic [4:0] hex_of(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") r = {1'b1, 4'(b - 8'h30)};
    else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - 8'h57)};
    else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] w, logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (w)
      2'd0: case (i) 3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                     default: c = 8'h00; endcase
      2'd1: case (i) 3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
                     3'd4: c = "e"; default: c = 8'h00; endcase
      2'd2: case (i) 3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                     default: c = 8'h00; endcase
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic pass_t noop(st_t s);
    pass_t p;
    p = '0;
    p.st = s;
    return p;
  endfunction

  function automatic pass_t emit1(pass_t p, logic [3:0] ev, logic [7:0] d);
    pass_t q;
    q = p;
    q.n = 3'd1;
    q.ev = ev;
    q.d[0] = d;
    return q;
  endfunction

  function automatic pass_t fail(pass_t p);
    pass_t q;
    q = emit1(p, EV_ERROR, 8'h00);
    q.st.er = 1'b1;
    return q;
  endfunction

  function automatic pass_t emit_utf(pass_t p, logic [31:0] c, logic [3:0] ev);
    pass_t q;
    q = p;
    q.ev = ev;
    if (c < 32'h80) begin
      q.n = 3'd1;
      q.d[0] = c[7:0];
    end else if (c < 32'h800) begin
      q.n = 3'd2;
      q.d[0] = 8'hC0 | c[13:6];
      q.d[1] = {2'b10, c[5:0]};
    end else if (c < 32'h10000) begin
      q.n = 3'd3;
      q.d[0] = 8'hE0 | c[19:12];
      q.d[1] = {2'b10, c[11:6]};
      q.d[2] = {2'b10, c[5:0]};
    end else begin
      q.n = 3'd4;
      q.d[0] = 8'hF0 | c[25:18];
      q.d[1] = {2'b10, c[17:12]};
      q.d[2] = {2'b10, c[11:6]};
      q.d[3] = {2'b10, c[5:0]};
    end
    return q;
  endfunction

  function automatic pass_t push_level(pass_t p, logic kind, logic [3:0] ev,
                                       logic [4:0] nxt);
    pass_t q;
    q = p;
    if (p.st.sp >= SP_MAX) begin
      q = fail(p);
    end else begin
      q.st.sp = p.st.sp + 1'b1;
      q.push = 1'b1;
      q.kind = kind;
      q = emit1(q, ev, 8'h00);
      q.st.mode = nxt;
    end
    return q;
  endfunction

  function automatic pass_t pop_level(pass_t p, logic [3:0] ev);
    pass_t q;
    q = p;
    if (p.st.sp != '0) q.st.sp = p.st.sp - 1'b1;
    q = emit1(q, ev, 8'h00);
    q.st.mode = M_AFTER;
    return q;
  endfunction

  function automatic pass_t start_value(pass_t p, logic [7:0] b);
    pass_t q;
    q = p;
    if (is_ws(b)) q = p;
    else if (b == "{") q = push_level(p, 1'b0, EV_OPEN_OBJ, M_OBJ_FIRST);
    else if (b == "[") q = push_level(p, 1'b1, EV_OPEN_ARR, M_ARR_FIRST);
    else if (b == "\"") q.st.mode = {2'b10, S_CHAR};
    else if (b == "t") begin q.st.mode = M_LIT_TRUE; q.st.lp = 3'd1; end
    else if (b == "f") begin q.st.mode = M_LIT_FALSE; q.st.lp = 3'd1; end
    else if (b == "n") begin q.st.mode = M_LIT_NULL; q.st.lp = 3'd1; end
    else if (is_num(b)) begin q = emit1(p, EV_NUM, b); q.st.mode = M_NUMBER; end
    else q = fail(p);
    return q;
  endfunction

  function automatic pass_t do_pass(st_t s, logic [7:0] b, logic top);
    pass_t       p;
    logic        kb;
    logic [2:0]  sub;
    logic [3:0]  sev;
    logic [4:0]  h;
    logic [15:0] acc;
    logic [2:0]  cnt;
    logic [31:0] code;
    logic [1:0]  w;
    logic [2:0]  len;
    p = noop(s);
    kb = s.mode[3];
    sub = s.mode[2:0];
    sev = kb ? EV_KEY : EV_STR;
    w = 2'(s.mode - M_LIT_TRUE);
    len = (w == 2'd1) ? 3'd5 : 3'd4;
    h = hex_of(b);
    acc = {s.ha[11:0], h[3:0]};
    cnt = s.hc + 1'b1;
    code = 32'h10000 + (({16'd0, s.hs} - 32'hD800) << 10) + {16'd0, acc} - 32'hDC00;
    if (s.mode[4]) begin
      case (sub)
        S_CHAR: begin
          if (b == "\"") begin
            p = emit1(p, EV_STR_END, 8'h00);
            p.st.mode = kb ? M_COLON : M_AFTER;
          end else if (b == "\\") begin
            p.st.mode = {1'b1, kb, S_ESC};
          end else begin
            p = emit1(p, sev, b);
          end
        end
        S_ESC: begin
          p.st.mode = {1'b1, kb, S_CHAR};
          if (b == "\"" || b == "\\" || b == "/") p = emit1(p, sev, b);
          else if (b == "b") p = emit1(p, sev, 8'h08);
          else if (b == "f") p = emit1(p, sev, 8'h0C);
          else if (b == "n") p = emit1(p, sev, 8'h0A);
          else if (b == "r") p = emit1(p, sev, 8'h0D);
          else if (b == "t") p = emit1(p, sev, 8'h09);
          else if (b == "u") begin
            p.st.ha = 16'd0;
            p.st.hc = 3'd0;
            p.st.mode = {1'b1, kb, S_HEX};
          end else p = fail(p);
        end
        S_HEX, S_LOW_HEX: begin
          if (!h[4]) begin
            p = fail(p);
          end else begin
            p.st.ha = acc;
            p.st.hc = cnt;
            if (cnt >= 3'd4) begin
              p.st.hc = 3'd0;
              if (sub == S_LOW_HEX) begin
                p = emit_utf(p, code, sev);
                p.st.mode = {1'b1, kb, S_CHAR};
              end else if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                p.st.hs = acc;
                p.st.mode = {1'b1, kb, S_AFTER_HI};
              end else begin
                p = emit_utf(p, {16'd0, acc}, sev);
                p.st.mode = {1'b1, kb, S_CHAR};
              end
            end
          end
        end
        S_AFTER_HI: begin
          if (b == "\\") begin
            p.st.mode = {1'b1, kb, S_AFTER_HI_BS};
          end else begin
            p = emit_utf(p, {16'd0, s.hs}, sev);
            p.st.mode = {1'b1, kb, S_CHAR};
            p.again = 1'b1;
          end
        end
        S_AFTER_HI_BS: begin
          if (b == "u") begin
            p.st.ha = 16'd0;
            p.st.hc = 3'd0;
            p.st.mode = {1'b1, kb, S_LOW_HEX};
          end else begin
            p = emit_utf(p, {16'd0, s.hs}, sev);
            p.st.mode = {1'b1, kb, S_ESC};
            p.again = 1'b1;
          end
        end
        default: p = fail(p);
      endcase
    end else begin
      case (s.mode)
        M_BOM: begin
          if (s.bp == 2'd0) begin
            if (b == 8'hEF) p.st.bp = 2'd1;
            else begin p.st.mode = M_VALUE; p.again = 1'b1; end
          end else if (s.bp == 2'd1) begin
            if (b == 8'hBB) p.st.bp = 2'd2; else p = fail(p);
          end else begin
            if (b == 8'hBF) p.st.mode = M_VALUE; else p = fail(p);
          end
        end
        M_VALUE: p = start_value(p, b);
        M_ARR_FIRST: begin
          if (b == "]") p = pop_level(p, EV_CLOSE_ARR);
          else p = start_value(p, b);
        end
        M_OBJ_FIRST: begin
          if (is_ws(b)) p = noop(s);
          else if (b == "}") p = pop_level(p, EV_CLOSE_OBJ);
          else if (b == "\"") p.st.mode = {2'b11, S_CHAR};
          else p = fail(p);
        end
        M_KEY: begin
          if (is_ws(b)) p = noop(s);
          else if (b == "\"") p.st.mode = {2'b11, S_CHAR};
          else p = fail(p);
        end
        M_COLON: begin
          if (is_ws(b)) p = noop(s);
          else if (b == ":") p.st.mode = M_VALUE;
          else p = fail(p);
        end
        M_AFTER: begin
          if (is_ws(b)) p = noop(s);
          else if (s.sp == '0) p = fail(p);
          else if (!top) begin
            if (b == ",") p.st.mode = M_KEY;
            else if (b == "}") p = pop_level(p, EV_CLOSE_OBJ);
            else p = fail(p);
          end else begin
            if (b == ",") p.st.mode = M_VALUE;
            else if (b == "]") p = pop_level(p, EV_CLOSE_ARR);
            else p = fail(p);
          end
        end
        M_NUMBER: begin
          if (is_num(b)) p = emit1(p, EV_NUM, b);
          else begin p.st.mode = M_AFTER; p.again = 1'b1; end
        end
        M_LIT_TRUE, M_LIT_FALSE, M_LIT_NULL: begin
          if (s.lp >= len || b != lit_char(w, s.lp)) begin
            p = fail(p);
          end else if (s.lp + 1'b1 == len) begin
            p.st.lp = 3'd0;
            p = emit1(p, EV_TRUE + {2'b00, w}, 8'h00);
            p.st.mode = M_AFTER;
          end else begin
            p.st.lp = s.lp + 1'b1;
          end
        end
        default: p = fail(p);
      endcase
    end
    return p;
  endfunction

  st_t            st_r, st_nxt;
  logic           bypass_r;
  logic           kind_r;
  logic           top;
  logic           ram_rdata;
  logic [SPW-1:0] rsp;
  pass_t          p1, p2;
  logic           lvl_push;
  logic           lvl_kind;
  logic [2:0]     k;

  assign top = bypass_r ? kind_r : ram_rdata;

  always_comb begin
    p1 = st_r.er ? noop(st_r) : do_pass(st_r, byte_value, top);
    p2 = (p1.again && !p1.st.er) ? do_pass(p1.st, byte_value, top) : noop(p1.st);
    bundle = '0;
    k = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < p1.n) begin
        bundle.ev[k] = p1.ev;
        bundle.data[k] = p1.d[i];
        bundle.depth[k] = 6'(p1.st.sp);
        k = k + 1'b1;
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < p2.n) begin
        bundle.ev[k] = p2.ev;
        bundle.data[k] = p2.d[i];
        bundle.depth[k] = 6'(p2.st.sp);
        k = k + 1'b1;
      end
    end
    if (final_byte && !p2.st.er) begin
      bundle.ev[k] = (p2.st.sp == '0 && (p2.st.mode == M_AFTER || p2.st.mode == M_NUMBER))
                     ? EV_DOC_OK : EV_ERROR;
      bundle.data[k] = 8'h00;
      bundle.depth[k] = 6'(p2.st.sp);
      k = k + 1'b1;
    end
    bundle.cnt = k;
    st_nxt = final_byte ? RST_ST : p2.st;
    lvl_push = p1.push || p2.push;
    lvl_kind = p1.push ? p1.kind : p2.kind;
  end

  assign push = accept && (k != 3'd0);
  // Prefetch the top of stack for the next word.
  assign rsp = accept ? st_nxt.sp : st_r.sp;

  jst_ram #(.WIDTH(1), .DEPTH(MAX_DEPTH)) u_stack (
    .clk   (clk),
    .we    (accept && lvl_push),
    .waddr (AW'(st_r.sp)),
    .wdata (lvl_kind),
    .raddr (AW'(rsp - 1'b1)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= RST_ST;
      bypass_r <= 1'b0;
    end else begin
      if (accept) begin
        st_r <= st_nxt;
      end
      bypass_r <= accept && lvl_push;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && lvl_push) begin
      kind_r <= lvl_kind;
    end
  end

endmodule

[hw/rtl/jst_queue.sv]
// Short FIFO of result bundles between front and back end.
module jst_queue import jst_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t wdata,
  input  logic    pop,
  output bundle_t head,
  output logic    full,
  output logic    empty
);

  localparam int PW = $clog2(Q_DEPTH);

  bundle_t     mem_r [Q_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = cnt_r == (PW + 1)'(Q_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

[hw/rtl/jst_back.sv]
// Back end: plays out one bundle a result word at a time from an output register.
module jst_back import jst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  bundle_t    head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_event_res,
  output logic [7:0] out_data_byte,
  output logic [5:0] out_nest_depth,
  output logic       out_end_of_run
);

  bundle_t    cur_r;
  logic [2:0] idx_r;
  logic       vld_r;
  logic       last;
  logic       load;

  assign last = idx_r == cur_r.cnt - 1'b1;
  assign load = !vld_r || (!out_stall && last);
  assign pop  = load && !empty;

  assign out_valid      = vld_r;
  assign out_event_res  = cur_r.ev[idx_r];
  assign out_data_byte  = cur_r.data[idx_r];
  assign out_nest_depth = cur_r.depth[idx_r];
  assign out_end_of_run = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 3'd0;
    end else if (load) begin
      vld_r <= !empty;
      idx_r <= 3'd0;
    end else if (!out_stall) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

endmodule

[hw/rtl/json_stream_tokenizer_core.sv]
// Top level of the streaming JSON tokenizer.
//
// Takes one byte of JSON text per cycle (in_final_byte on the last byte) and
// emits structure events, decoded string bytes and raw number bytes, one result
// word per cycle while out_stall is low. A byte is taken every cycle as long as
// the four-entry bundle queue between the grammar front end and the output back
// end has room; each byte yields zero to five results, and the single output
// register drains one per cycle unless out_stall holds it, so sustained input
// rate is one byte per cycle for bytes giving at most one result, and otherwise
// set by the result count. Nesting kind is kept in a MAX_DEPTH x 1 RAM whose
// top entry is prefetched each cycle; it needs no clearing after reset.
module json_stream_tokenizer_core import jst_pkg::*; #(
  parameter int MAX_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_event_res,
  output logic [7:0] out_data_byte,
  output logic [5:0] out_nest_depth,
  output logic       out_end_of_run
);

  bundle_t q_wdata, q_head;
  logic    q_push, q_pop, q_full, q_empty;

  assign in_stall = q_full;

  jst_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_valid && !q_full),
    .byte_value (in_byte_value),
    .final_byte (in_final_byte),
    .push       (q_push),
    .bundle     (q_wdata)
  );

  jst_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  jst_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .empty          (q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .out_data_byte  (out_data_byte),
    .out_nest_depth (out_nest_depth),
    .out_end_of_run (out_end_of_run)
  );

endmodule
